### rtl/ttc_pkg.sv
package ttc_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int CW            = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int FIELD_W       = 32;
  localparam int DW            = CW + 1;
  localparam int PW            = 2 * DW;
  localparam int AW            = PW + 1;
  localparam int DIV_CNT_W     = $clog2(CW);
  localparam int MUL_STEPS     = 8;
  localparam int MUL_SEL_W     = $clog2(MUL_STEPS);
  localparam int MUL_CNT_W     = MUL_SEL_W + 1;

  typedef struct packed {
    logic                 latch_a;
    logic                 latch_b;
    logic                 latch_c;
    logic                 load_delta;
    logic                 mul_en;
    logic [MUL_SEL_W-1:0] mul_sel;
    logic                 acc_en;
    logic [MUL_SEL_W-1:0] acc_sel;
    logic                 prep;
    logic                 div_init;
    logic                 div_step;
    logic                 load_out;
  } cmd_t;

  function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] x);
    return x[AW-1] ? AW'(-x) : AW'(x);
  endfunction

endpackage

### rtl/ttc_if.sv
interface ttc_corner_if;
  import ttc_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] vert_id;
  logic [FIELD_W-1:0] pos_x;
  logic [FIELD_W-1:0] pos_y;
  logic [FIELD_W-1:0] pos_z;
  logic [FIELD_W-1:0] tex_u;
  logic [FIELD_W-1:0] tex_v;

  modport source (output valid, input ready,
                  output vert_id, pos_x, pos_y, pos_z, tex_u, tex_v);
  modport sink   (input valid, output ready,
                  input vert_id, pos_x, pos_y, pos_z, tex_u, tex_v);
endinterface

interface ttc_result_if;
  import ttc_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] corner_a_index;
  logic [FIELD_W-1:0] corner_b_index;
  logic [FIELD_W-1:0] corner_c_index;
  logic [FIELD_W-1:0] tangent_x;
  logic [FIELD_W-1:0] tangent_y;
  logic [FIELD_W-1:0] tangent_z;
  logic               degenerate;

  modport source (output valid, input ready,
                  output corner_a_index, corner_b_index, corner_c_index,
                  output tangent_x, tangent_y, tangent_z, degenerate);
  modport sink   (input valid, output ready,
                  input corner_a_index, corner_b_index, corner_c_index,
                  input tangent_x, tangent_y, tangent_z, degenerate);
endinterface

### rtl/ttc_ctrl.sv
module ttc_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output ttc_pkg::cmd_t cmd
);
  import ttc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DELTA = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_PREP  = 7'b0001000,
    S_INIT  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_WRITE = 7'b1000000
  } state_t;

  state_t               state, state_next;
  logic [1:0]           corner_cnt, corner_cnt_next;
  logic [MUL_CNT_W-1:0] mul_cnt, mul_cnt_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 out_valid_next;
  logic                 accept;
  logic                 out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next      = state;
    corner_cnt_next = corner_cnt;
    mul_cnt_next    = mul_cnt;
    div_cnt_next    = div_cnt;
    out_valid_next  = out_valid && !out_ready;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (corner_cnt)
            2'd1: begin
              cmd.latch_b     = 1'b1;
              corner_cnt_next = 2'd2;
            end
            2'd2: begin
              cmd.latch_c     = 1'b1;
              corner_cnt_next = 2'd0;
              state_next      = S_DELTA;
            end
            default: begin
              cmd.latch_a     = 1'b1;
              corner_cnt_next = 2'd1;
            end
          endcase
        end
      end
      S_DELTA: begin
        cmd.load_delta = 1'b1;
        mul_cnt_next   = '0;
        state_next     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en  = (mul_cnt < MUL_CNT_W'(MUL_STEPS));
        cmd.mul_sel = mul_cnt[MUL_SEL_W-1:0];
        cmd.acc_en  = (mul_cnt != '0);
        cmd.acc_sel = MUL_SEL_W'(mul_cnt - MUL_CNT_W'(1));
        mul_cnt_next = mul_cnt + MUL_CNT_W'(1);
        if (mul_cnt == MUL_CNT_W'(MUL_STEPS)) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        div_cnt_next = DIV_CNT_W'(CW - 1);
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt - DIV_CNT_W'(1);
        if (div_cnt == '0) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      corner_cnt <= 2'd0;
      mul_cnt    <= '0;
      div_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      corner_cnt <= corner_cnt_next;
      mul_cnt    <= mul_cnt_next;
      div_cnt    <= div_cnt_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

### rtl/ttc_dp.sv
module ttc_dp (
  input  logic          clk,
  input  ttc_pkg::cmd_t cmd,
  ttc_corner_if.sink    corner,
  ttc_result_if.source  result
);
  import ttc_pkg::*;

  logic signed [CW-1:0] pa [3];
  logic signed [CW-1:0] pb [3];
  logic signed [CW-1:0] pc [3];
  logic signed [CW-1:0] ua [2];
  logic signed [CW-1:0] ub [2];
  logic signed [CW-1:0] uc [2];
  logic [FIELD_W-1:0]   ia, ib, ic;

  logic signed [DW-1:0] du1, dv1, du2, dv2;
  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] e2 [3];

  logic signed [DW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc_first;
  logic signed [AW-1:0] det;
  logic signed [AW-1:0] num [3];

  logic [AW-1:0]        ud;
  logic [AW-1:0]        un [3];
  logic                 neg [3];
  logic                 degen;

  logic [AW-1:0]        rem [3];
  logic [CW-1:0]        lo [3];
  logic [CW-1:0]        quo [3];
  logic                 ovf [3];

  logic signed [CW-1:0] tan [3];

  always_comb begin
    case (cmd.mul_sel)
      3'd0:    begin op_a = du1; op_b = dv2;   end
      3'd1:    begin op_a = du2; op_b = dv1;   end
      3'd2:    begin op_a = dv2; op_b = e1[0]; end
      3'd3:    begin op_a = dv1; op_b = e2[0]; end
      3'd4:    begin op_a = dv2; op_b = e1[1]; end
      3'd5:    begin op_a = dv1; op_b = e2[1]; end
      3'd6:    begin op_a = dv2; op_b = e1[2]; end
      3'd7:    begin op_a = dv1; op_b = e2[2]; end
      default: begin op_a = '0;  op_b = '0;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_a || cmd.latch_b || cmd.latch_c) begin
      if (cmd.latch_a) begin
        pa[0] <= corner.pos_x[CW-1:0];
        pa[1] <= corner.pos_y[CW-1:0];
        pa[2] <= corner.pos_z[CW-1:0];
        ua[0] <= corner.tex_u[CW-1:0];
        ua[1] <= corner.tex_v[CW-1:0];
        ia    <= corner.vert_id;
      end
      if (cmd.latch_b) begin
        pb[0] <= corner.pos_x[CW-1:0];
        pb[1] <= corner.pos_y[CW-1:0];
        pb[2] <= corner.pos_z[CW-1:0];
        ub[0] <= corner.tex_u[CW-1:0];
        ub[1] <= corner.tex_v[CW-1:0];
        ib    <= corner.vert_id;
      end
      if (cmd.latch_c) begin
        pc[0] <= corner.pos_x[CW-1:0];
        pc[1] <= corner.pos_y[CW-1:0];
        pc[2] <= corner.pos_z[CW-1:0];
        uc[0] <= corner.tex_u[CW-1:0];
        uc[1] <= corner.tex_v[CW-1:0];
        ic    <= corner.vert_id;
      end
    end

    if (cmd.load_delta) begin
      du1 <= DW'(ub[0]) - DW'(ua[0]);
      dv1 <= DW'(ub[1]) - DW'(ua[1]);
      du2 <= DW'(uc[0]) - DW'(ua[0]);
      dv2 <= DW'(uc[1]) - DW'(ua[1]);
      for (int i = 0; i < 3; i++) begin
        e1[i] <= DW'(pb[i]) - DW'(pa[i]);
        e2[i] <= DW'(pc[i]) - DW'(pa[i]);
      end
    end

    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end

    // even step holds the first product, odd step subtracts the second
    if (cmd.acc_en) begin
      if (!cmd.acc_sel[0]) begin
        acc_first <= AW'(prod);
      end else begin
        case (cmd.acc_sel[2:1])
          2'd0:    det    <= acc_first - AW'(prod);
          2'd1:    num[0] <= acc_first - AW'(prod);
          2'd2:    num[1] <= acc_first - AW'(prod);
          default: num[2] <= acc_first - AW'(prod);
        endcase
      end
    end

    if (cmd.prep) begin
      ud    <= mag(det);
      degen <= (det == '0);
      for (int i = 0; i < 3; i++) begin
        un[i]  <= mag(num[i]);
        neg[i] <= num[i][AW-1] ^ det[AW-1];
      end
    end

    // quotient beyond CW bits is caught up front and saturated
    if (cmd.div_init) begin
      for (int i = 0; i < 3; i++) begin
        rem[i] <= AW'(un[i][AW-1:CW-FRACTION_BITS]);
        lo[i]  <= CW'({un[i], FRACTION_BITS'(0)});
        ovf[i] <= (AW'(un[i][AW-1:CW-FRACTION_BITS]) >= ud);
        quo[i] <= '0;
      end
    end

    if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        if ({rem[i], lo[i][CW-1]} >= {1'b0, ud}) begin
          rem[i] <= AW'({rem[i], lo[i][CW-1]} - {1'b0, ud});
          quo[i] <= {quo[i][CW-2:0], 1'b1};
        end else begin
          rem[i] <= {rem[i][AW-2:0], lo[i][CW-1]};
          quo[i] <= {quo[i][CW-2:0], 1'b0};
        end
        lo[i] <= {lo[i][CW-2:0], 1'b0};
      end
    end

    if (cmd.load_out) begin
      result.corner_a_index <= ia;
      result.corner_b_index <= ib;
      result.corner_c_index <= ic;
      result.tangent_x      <= FIELD_W'(tan[0]);
      result.tangent_y      <= FIELD_W'(tan[1]);
      result.tangent_z      <= FIELD_W'(tan[2]);
      result.degenerate     <= degen;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (degen) begin
        tan[i] = '0;
      end else if (neg[i]) begin
        if (ovf[i] || (quo[i] > {1'b1, (CW-1)'(0)})) begin
          tan[i] = {1'b1, (CW-1)'(0)};
        end else begin
          tan[i] = -$signed(quo[i]);
        end
      end else begin
        if (ovf[i] || quo[i][CW-1]) begin
          tan[i] = {1'b0, {(CW-1){1'b1}}};
        end else begin
          tan[i] = $signed(quo[i]);
        end
      end
    end
  end

endmodule

### rtl/triangle_tangent_calculator_unit.sv
// channel | dir | words                      | handshake
// corner  | in  | one word per corner        | valid/ready
// result  | out | one word per third corner  | valid/ready
//
// First and second corners of a triangle are taken with ready held high in idle.
// Third corner: ready stays low until its result is loaded, a wait set by the
// single shared 33x33 multiplier (8 products) and the bit-per-cycle divider
// running three lanes against one determinant.
// Result is held in an output register; the next corners are taken while it waits,
// and a later result stalls in the write state until the held one is taken.
// rst is synchronous and clears the corner count, state and output valid.
module triangle_tangent_calculator_unit (
  input  logic         clk,
  input  logic         rst,
  ttc_corner_if.sink   corner,
  ttc_result_if.source result
);
  import ttc_pkg::*;

  cmd_t cmd;

  ttc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (corner.valid),
    .in_ready  (corner.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  ttc_dp u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .corner (corner),
    .result (result)
  );

endmodule

### test/tb_triangle_tangent_calculator_unit.sv
`timescale 1ns / 100ps

module tb_triangle_tangent_calculator_unit;
  import ttc_pkg::*;

  localparam logic [FIELD_W-1:0] ONE = 32'h0001_0000;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [FIELD_W-1:0] vert_id;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] pos_z;
    logic [FIELD_W-1:0] tex_u;
    logic [FIELD_W-1:0] tex_v;
  } corner_t;

  typedef struct packed {
    logic [FIELD_W-1:0] a_idx;
    logic [FIELD_W-1:0] b_idx;
    logic [FIELD_W-1:0] c_idx;
    logic [FIELD_W-1:0] tx;
    logic [FIELD_W-1:0] ty;
    logic [FIELD_W-1:0] tz;
    logic               degen;
  } tangent_res_t;

  typedef struct packed {
    corner_t            c;
    logic               typed;
    logic [FIELD_W-1:0] tx;
    logic [FIELD_W-1:0] ty;
    logic [FIELD_W-1:0] tz;
    logic               degen;
  } corner_row_t;

  logic clk;
  logic rst;

  ttc_corner_if corner_ch ();
  ttc_result_if result_ch ();

  triangle_tangent_calculator_unit uut (
    .clk    (clk),
    .rst    (rst),
    .corner (corner_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  tangent_res_t expected_tangents[$];
  tangent_res_t due;
  corner_t      latched_a;
  corner_t      latched_b;
  logic [1:0]   corners_held;
  int           err_count = 0;
  int           burst_left;
  logic [9:0]   sink_tick;

  function automatic wide_t coord(input logic [FIELD_W-1:0] raw);
    logic signed [CW-1:0] v;
    v = raw[CW-1:0];
    return v;
  endfunction

  function automatic logic [FIELD_W-1:0] tangent_lane(input wide_t e1, e2, dv1, dv2, det);
    wide_t num;
    wide_t quo;
    wide_t lim_hi;
    wide_t lim_lo;
    lim_hi = (128'sd1 <<< (CW - 1)) - 128'sd1;
    lim_lo = -(128'sd1 <<< (CW - 1));
    num = dv2 * e1 - dv1 * e2;
    quo = (num <<< FRACTION_BITS) / det;
    if (quo > lim_hi) quo = lim_hi;
    else if (quo < lim_lo) quo = lim_lo;
    return quo[FIELD_W-1:0];
  endfunction

  // returns 1 when the corner closes a triangle and a result is queued
  function automatic bit take_corner(input corner_t c);
    tangent_res_t r;
    wide_t du1, dv1, du2, dv2, det;
    if (corners_held == 2'd3) corners_held = 2'd0;
    case (corners_held)
      2'd0: begin
        latched_a = c;
        corners_held = 2'd1;
        return 1'b0;
      end
      2'd1: begin
        latched_b = c;
        corners_held = 2'd2;
        return 1'b0;
      end
      default: begin
        corners_held = 2'd0;
        du1 = coord(latched_b.tex_u) - coord(latched_a.tex_u);
        dv1 = coord(latched_b.tex_v) - coord(latched_a.tex_v);
        du2 = coord(c.tex_u) - coord(latched_a.tex_u);
        dv2 = coord(c.tex_v) - coord(latched_a.tex_v);
        det = du1 * dv2 - du2 * dv1;
        r.a_idx = latched_a.vert_id;
        r.b_idx = latched_b.vert_id;
        r.c_idx = c.vert_id;
        if (det == 0) begin
          r.tx = '0;
          r.ty = '0;
          r.tz = '0;
          r.degen = 1'b1;
        end else begin
          r.tx = tangent_lane(coord(latched_b.pos_x) - coord(latched_a.pos_x),
                              coord(c.pos_x) - coord(latched_a.pos_x), dv1, dv2, det);
          r.ty = tangent_lane(coord(latched_b.pos_y) - coord(latched_a.pos_y),
                              coord(c.pos_y) - coord(latched_a.pos_y), dv1, dv2, det);
          r.tz = tangent_lane(coord(latched_b.pos_z) - coord(latched_a.pos_z),
                              coord(c.pos_z) - coord(latched_a.pos_z), dv1, dv2, det);
          r.degen = 1'b0;
        end
        expected_tangents = {expected_tangents, r};
        return 1'b1;
      end
    endcase
  endfunction

  function automatic corner_row_t crow(input logic [FIELD_W-1:0] idx, px, py, pz, tu, tv);
    corner_row_t r;
    r = '0;
    r.c = '{idx, px, py, pz, tu, tv};
    return r;
  endfunction

  function automatic corner_row_t close_row(input logic [FIELD_W-1:0] idx, px, py, pz, tu, tv,
                                            input logic [FIELD_W-1:0] tx, ty, tz,
                                            input logic degen);
    corner_row_t r;
    r = crow(idx, px, py, pz, tu, tv);
    r.typed = 1'b1;
    r.tx = tx;
    r.ty = ty;
    r.tz = tz;
    r.degen = degen;
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] near_zero(input int span);
    return FIELD_W'($urandom_range(0, 2 * span)) - FIELD_W'(span);
  endfunction

  function void check_field(input string name, input logic [FIELD_W-1:0] want, got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_count++;
    end
  endfunction

  // typed is only used on triangle-closing rows; indices come from the caller
  task automatic send_word(input corner_t c, input bit typed, input tangent_res_t typed_res);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 6);
      gap = $urandom_range(1, 6);
      corner_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    corner_ch.valid   <= 1'b1;
    corner_ch.vert_id <= c.vert_id;
    corner_ch.pos_x   <= c.pos_x;
    corner_ch.pos_y   <= c.pos_y;
    corner_ch.pos_z   <= c.pos_z;
    corner_ch.tex_u   <= c.tex_u;
    corner_ch.tex_v   <= c.tex_v;
    do @(posedge clk); while (!corner_ch.ready);
    if (take_corner(c) && typed)
      expected_tangents[expected_tangents.size() - 1] = typed_res;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_tick <= '0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_tangents.size() == 0) begin
          $error("result word with nothing expected");
          err_count++;
        end else begin
          due = expected_tangents.pop_front();
          check_field("corner_a_index", due.a_idx, result_ch.corner_a_index);
          check_field("corner_b_index", due.b_idx, result_ch.corner_b_index);
          check_field("corner_c_index", due.c_idx, result_ch.corner_c_index);
          check_field("tangent_x", due.tx, result_ch.tangent_x);
          check_field("tangent_y", due.ty, result_ch.tangent_y);
          check_field("tangent_z", due.tz, result_ch.tangent_z);
          check_field("degenerate", FIELD_W'(due.degen), FIELD_W'(result_ch.degenerate));
        end
      end
      sink_tick <= sink_tick + 1'b1;
      case (sink_tick[9:8])
        2'd0:    result_ch.ready <= 1'b1;
        2'd1:    result_ch.ready <= ($urandom_range(0, 1) == 0);
        2'd2:    result_ch.ready <= (sink_tick[3:0] == 4'd0);
        default: result_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    corner_row_t  dir_rows[$];
    corner_t      tri_c[3];
    tangent_res_t typed_res;
    logic [FIELD_W-1:0] du, dv;
    int n_sent;
    int mode;
    int k;
    int i;
    int j;

    clk = 1'b0;
    rst = 1'b1;
    corner_ch.valid = 1'b0;
    corner_ch.vert_id = '0;
    corner_ch.pos_x = '0;
    corner_ch.pos_y = '0;
    corner_ch.pos_z = '0;
    corner_ch.tex_u = '0;
    corner_ch.tex_v = '0;
    burst_left = 0;
    corners_held = '0;
    latched_a = '0;
    latched_b = '0;

    dir_rows = '{
      // equal UVs: zero determinant, index extremes
      crow(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1234_5678, 32'h9ABC_DEF0),
      crow(32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3, 32'h1234_5678, 32'h9ABC_DEF0),
      close_row(32'h8000_0000, 32'hFFFF_FFFB, 32'h7, 32'h8000_0000,
                32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 32'h0, 32'h0, 1'b1),
      // unit triangle, tangent along x
      crow(32'd10, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
      crow(32'd11, ONE, 32'h0, 32'h0, ONE, 32'h0),
      close_row(32'd12, 32'h0, ONE, 32'h0, 32'h0, ONE, ONE, 32'h0, 32'h0, 1'b0),
      // determinant of one LSB squared: both saturation limits
      crow(32'd20, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
      crow(32'd21, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'h0),
      close_row(32'd22, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0),
      // swapped UVs, negative determinant
      crow(32'd30, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
      crow(32'd31, ONE, 32'h0, 32'h0, 32'h0, ONE),
      close_row(32'd32, 32'h0, ONE, 32'h0, ONE, 32'h0, 32'h0, ONE, 32'h0, 1'b0),
      // field extremes
      crow(32'h5A5A_5A5A, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000, 32'h8000_0000),
      crow(32'hA5A5_A5A5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           32'h7FFF_FFFF, 32'h7FFF_FFFF),
      crow(32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
           32'h7FFF_FFFF, 32'h8000_0000),
      // collinear UVs: zero determinant with distinct coordinates
      crow(32'd40, 32'h0003_8000, 32'hFFFE_0000, 32'h0000_4000, 32'h0, 32'h0),
      crow(32'd41, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, ONE, 2 * ONE),
      close_row(32'd42, 32'h0000_1000, 32'h0004_0000, 32'h7000_0000, 2 * ONE, 4 * ONE,
                32'h0, 32'h0, 32'h0, 1'b1),
      // fractional mix
      crow(32'd50, 32'h0001_8000, 32'hFFFF_4000, 32'h0002_0001, 32'h0000_2000, 32'h0000_C000),
      crow(32'd51, 32'hFFFD_0000, 32'h0000_0123, 32'h0010_0000, 32'h0001_3000, 32'hFFFF_8000),
      crow(32'd52, 32'h0000_7FFF, 32'h0003_0000, 32'hFFF0_0000, 32'hFFFF_F000, 32'h0002_1000)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < dir_rows.size(); i++) begin
      typed_res = '0;
      if (dir_rows[i].typed)
        typed_res = '{dir_rows[i-2].c.vert_id, dir_rows[i-1].c.vert_id,
                      dir_rows[i].c.vert_id, dir_rows[i].tx, dir_rows[i].ty,
                      dir_rows[i].tz, dir_rows[i].degen};
      send_word(dir_rows[i].c, dir_rows[i].typed, typed_res);
    end

    n_sent = 0;
    while (n_sent < 1000) begin
      mode = $urandom_range(0, 19);
      for (j = 0; j < 3; j++) begin
        tri_c[j].vert_id = $urandom;
        if (mode < 10 || mode >= 15) begin
          tri_c[j].pos_x = $urandom;
          tri_c[j].pos_y = $urandom;
          tri_c[j].pos_z = $urandom;
          tri_c[j].tex_u = $urandom;
          tri_c[j].tex_v = $urandom;
        end else begin
          tri_c[j].pos_x = near_zero(1 << 18);
          tri_c[j].pos_y = near_zero(1 << 18);
          tri_c[j].pos_z = near_zero(1 << 18);
          tri_c[j].tex_u = near_zero(1 << 18);
          tri_c[j].tex_v = near_zero(1 << 18);
        end
      end
      if (mode == 15 || mode == 16) begin
        // collinear UVs
        tri_c[0].tex_u = near_zero(1 << 18);
        tri_c[0].tex_v = near_zero(1 << 18);
        du = near_zero(1 << 17);
        dv = near_zero(1 << 17);
        k = $urandom_range(0, 4) - 2;
        tri_c[1].tex_u = tri_c[0].tex_u + du;
        tri_c[1].tex_v = tri_c[0].tex_v + dv;
        tri_c[2].tex_u = tri_c[0].tex_u + FIELD_W'(k) * du;
        tri_c[2].tex_v = tri_c[0].tex_v + FIELD_W'(k) * dv;
      end else if (mode >= 17) begin
        // UV deltas of a few LSBs: tiny determinant, saturation likely
        for (j = 1; j < 3; j++) begin
          tri_c[j].tex_u = tri_c[0].tex_u + near_zero(3);
          tri_c[j].tex_v = tri_c[0].tex_v + near_zero(3);
        end
      end
      for (j = 0; j < 3; j++)
        send_word(tri_c[j], 1'b0, '0);
      n_sent += 3;
    end

    corner_ch.valid <= 1'b0;
    while (expected_tangents.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (err_count == 0 && expected_tangents.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
